>>> src/jbmc_pkg.sv
// ---------------------------------------------------------------------------
// JPEG baseline marker check package
// Types and constants shared by the marker-walking checker: parse phases,
// marker codes, segment offsets and the fixed-point density constants.
// ---------------------------------------------------------------------------
package jbmc_pkg;

    typedef enum logic [2:0] {
        PH_SOI0   = 3'd0,
        PH_SOI1   = 3'd1,
        PH_PREFIX = 3'd2,
        PH_MARKER = 3'd3,
        PH_LENHI  = 3'd4,
        PH_LENLO  = 3'd5,
        PH_BODY   = 3'd6
    } t_phase;

    typedef logic [16:0] t_offset;
    typedef logic [15:0] t_length;
    typedef logic [7:0]  t_byte;
    typedef logic [22:0] t_dpm;

    localparam t_byte MK_PREFIX   = 8'hFF;
    localparam t_byte MK_SOI      = 8'hD8;
    localparam t_byte MK_TEM      = 8'h01;
    localparam t_byte MK_RST_LO   = 8'hD0;
    localparam t_byte MK_RST_HI   = 8'hD7;
    localparam t_byte MK_SOF0     = 8'hC0;
    localparam t_byte MK_SOF1     = 8'hC1;
    localparam t_byte MK_SOF_LO   = 8'hC2;
    localparam t_byte MK_SOF_HI   = 8'hCF;
    localparam t_byte MK_DHT      = 8'hC4;
    localparam t_byte MK_JPG      = 8'hC8;
    localparam t_byte MK_DAC      = 8'hCC;
    localparam t_byte MK_SOS      = 8'hDA;
    localparam t_byte MK_APP0     = 8'hE0;

    localparam t_length LEN_MIN      = 16'd2;
    localparam t_length LEN_JFIF_MIN = 16'd16;

    localparam t_offset OFF_LEN_DONE  = 17'd3;
    localparam t_offset OFF_SIG_FIRST = 17'd4;
    localparam t_offset OFF_SIG_LAST  = 17'd8;
    localparam t_offset OFF_COMP      = 17'd9;
    localparam t_offset OFF_UNITS     = 17'd11;
    localparam t_offset OFF_XHI       = 17'd12;
    localparam t_offset OFF_XLO       = 17'd13;
    localparam t_offset OFF_YHI       = 17'd14;
    localparam t_offset OFF_YLO       = 17'd15;

    localparam t_byte COMP_GREY   = 8'd1;
    localparam t_byte COMP_COLOUR = 8'd3;

    localparam t_byte UNITS_INCH = 8'd1;
    localparam t_byte UNITS_CM   = 8'd2;

    localparam t_byte JFIF_SIG [5] = '{8'h4A, 8'h46, 8'h49, 8'h46, 8'h00};

    // Inch density: (v*10000 + 127) / 254 equals (v*5000 + 63) / 127.
    localparam logic [12:0] INCH_MUL  = 13'd5000;
    localparam logic [5:0]  INCH_ADD  = 6'd63;
    localparam logic [6:0]  INCH_DIV  = 7'd127;
    localparam logic [29:0] INCH_RECIP = 30'd541098242;
    localparam int          INCH_SHIFT = 36;
    localparam logic [6:0]  CM_MUL    = 7'd100;

endpackage

>>> src/jpeg_baseline_marker_check.sv
// ---------------------------------------------------------------------------
// JPEG baseline marker check
// Walks the marker segments of a JPEG file presented one byte per word and
// gives one verdict per file, with the component count and JFIF density.
//
//   channel   direction  handshake                   payload
//   input     in         i_in_valid / o_in_ready     byte value, last byte flag
//   result    out        o_out_valid / i_out_ready   verdict, components, density
//
// One input word is taken every cycle unless the result stalls; a result is
// written from its word through the input register, then the result register.
// The density conversion runs in a three-stage multiply pipeline beside the
// parser; it finishes long before any later SOF segment can be accepted.
// Reset is synchronous; it clears the parser and the saved density.
// A stalled result holds the parser; one further word is held in the input
// register meanwhile.
// ---------------------------------------------------------------------------
module jpeg_baseline_marker_check (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  jbmc_pkg::t_byte       i_byte_value,
    input  logic                  i_last_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_accepted,
    output jbmc_pkg::t_byte       o_component_count,
    output jbmc_pkg::t_dpm        o_dots_per_meter_x,
    output jbmc_pkg::t_dpm        o_dots_per_meter_y
);
    import jbmc_pkg::*;

    logic    r_in_valid;
    t_byte   r_in_byte;
    logic    r_in_last;

    t_phase  r_phase, n_phase;
    t_offset r_off, n_off;
    t_length r_len, n_len;
    t_byte   r_marker, n_marker;
    logic    r_sig_ok, n_sig_ok;
    t_byte   r_units, n_units;
    t_length r_dx, n_dx;
    t_length r_dy, n_dy;
    t_dpm    r_saved_x, r_saved_y;
    t_byte   r_comp, n_comp;
    logic    r_verdict_given, n_verdict_given;

    logic    r_out_valid;
    logic    r_out_acc;
    t_byte   r_out_comp;
    t_dpm    r_out_dx, r_out_dy;

    logic    w_stall, w_fire;
    logic    w_reject, w_accept, w_result;
    t_offset w_off;
    t_length w_len;
    t_offset w_target;
    logic    w_end;
    logic    w_is_sof, w_is_jfif;
    logic    w_standalone, w_bad_marker;
    logic    w_sig_match;
    logic    w_density_go;

    // Density pipeline, one lane for each axis.
    logic        r_da_valid, r_db_valid, r_dc_valid;
    t_byte       r_da_units, r_db_units, r_dc_units;
    t_length     r_da_v [2];
    logic [28:0] r_db_m [2];
    t_dpm        r_db_h [2];
    logic [28:0] r_dc_m [2];
    t_dpm        r_dc_h [2];
    logic [58:0] r_dc_prod [2];
    t_dpm        w_dpm [2];

    assign w_stall    = r_out_valid && !i_out_ready;
    assign w_fire     = r_in_valid && !w_stall;
    assign o_in_ready = !r_in_valid || !w_stall;

    assign w_is_sof  = (r_marker == MK_SOF0) || (r_marker == MK_SOF1);
    assign w_off     = (r_phase == PH_LENLO) ? OFF_LEN_DONE : r_off + 17'd1;
    assign w_len     = (r_phase == PH_LENLO) ? {r_len[15:8], r_in_byte} : r_len;
    assign w_is_jfif = (r_marker == MK_APP0) && (w_len >= LEN_JFIF_MIN);
    assign w_end     = (w_off >= w_target);

    always_comb begin
        w_target = {1'b0, w_len} + 17'd1;
        if (w_is_sof && (w_target < OFF_COMP)) begin
            w_target = OFF_COMP;
        end
    end

    assign w_standalone = (r_in_byte == MK_SOI) || (r_in_byte == MK_TEM)
        || ((r_in_byte >= MK_RST_LO) && (r_in_byte <= MK_RST_HI));
    assign w_bad_marker = ((r_in_byte >= MK_SOF_LO) && (r_in_byte <= MK_SOF_HI)
        && (r_in_byte != MK_DHT) && (r_in_byte != MK_JPG) && (r_in_byte != MK_DAC))
        || (r_in_byte == MK_SOS);

    always_comb begin
        t_offset sig_idx;
        sig_idx     = w_off - OFF_SIG_FIRST;
        w_sig_match = (r_in_byte == JFIF_SIG[sig_idx[2:0]]);
    end

    // Verdict decode.
    always_comb begin
        w_reject = 1'b0;
        w_accept = 1'b0;
        if (!r_verdict_given) begin
            case (r_phase)
                PH_SOI0:   w_reject = (r_in_byte != MK_PREFIX);
                PH_SOI1:   w_reject = (r_in_byte != MK_SOI);
                PH_PREFIX: w_reject = (r_in_byte != MK_PREFIX);
                PH_MARKER: w_reject = !w_standalone && w_bad_marker;
                PH_LENHI:  w_reject = 1'b0;
                PH_LENLO: begin
                    w_reject = (w_len < LEN_MIN);
                    w_accept = !w_reject && w_is_sof && w_end;
                end
                PH_BODY: begin
                    w_reject = w_is_sof && (w_off == OFF_COMP)
                        && (r_in_byte != COMP_GREY) && (r_in_byte != COMP_COLOUR);
                    w_accept = !w_reject && w_is_sof && w_end;
                end
                default:   w_reject = 1'b1;
            endcase
        end
    end

    assign w_result = w_reject || w_accept || (r_in_last && !r_verdict_given);

    // Next-state decode.
    always_comb begin
        n_phase         = r_phase;
        n_off           = r_off;
        n_len           = r_len;
        n_marker        = r_marker;
        n_sig_ok        = r_sig_ok;
        n_units         = r_units;
        n_dx            = r_dx;
        n_dy            = r_dy;
        n_comp          = r_comp;
        n_verdict_given = r_verdict_given || w_result;
        w_density_go    = 1'b0;
        if (!r_verdict_given) begin
            case (r_phase)
                PH_SOI0:   n_phase = PH_SOI1;
                PH_SOI1:   n_phase = PH_PREFIX;
                PH_PREFIX: n_phase = PH_MARKER;
                PH_MARKER: begin
                    if (w_standalone) begin
                        n_phase = PH_PREFIX;
                    end else begin
                        n_marker = r_in_byte;
                        n_phase  = PH_LENHI;
                    end
                end
                PH_LENHI: begin
                    n_len   = {r_in_byte, 8'h00};
                    n_phase = PH_LENLO;
                end
                PH_LENLO: begin
                    n_len    = w_len;
                    n_off    = w_off;
                    n_sig_ok = 1'b0;
                    n_phase  = w_end ? PH_PREFIX : PH_BODY;
                end
                PH_BODY: begin
                    n_off = w_off;
                    if (w_is_jfif) begin
                        if ((w_off >= OFF_SIG_FIRST) && (w_off <= OFF_SIG_LAST)) begin
                            n_sig_ok = ((w_off == OFF_SIG_FIRST) || r_sig_ok) && w_sig_match;
                        end else if (w_off == OFF_UNITS) begin
                            n_units = r_in_byte;
                        end else if (w_off == OFF_XHI) begin
                            n_dx = {r_in_byte, 8'h00};
                        end else if (w_off == OFF_XLO) begin
                            n_dx = {r_dx[15:8], r_in_byte};
                        end else if (w_off == OFF_YHI) begin
                            n_dy = {r_in_byte, 8'h00};
                        end else if (w_off == OFF_YLO) begin
                            n_dy         = {r_dy[15:8], r_in_byte};
                            w_density_go = r_sig_ok;
                        end
                    end
                    if (w_is_sof && (w_off == OFF_COMP)) begin
                        n_comp = r_in_byte;
                    end
                    n_phase = w_end ? PH_PREFIX : PH_BODY;
                end
                default:   n_phase = r_phase;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready) begin
            r_in_byte <= i_byte_value;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_fire && r_in_last)) begin
            r_phase         <= PH_SOI0;
            r_verdict_given <= 1'b0;
            r_off           <= '0;
            r_len           <= '0;
            r_marker        <= '0;
            r_sig_ok        <= 1'b0;
            r_units         <= '0;
            r_dx            <= '0;
            r_dy            <= '0;
            r_comp          <= '0;
        end else if (w_fire) begin
            r_phase         <= n_phase;
            r_verdict_given <= n_verdict_given;
            r_off           <= n_off;
            r_len           <= n_len;
            r_marker        <= n_marker;
            r_sig_ok        <= n_sig_ok;
            r_units         <= n_units;
            r_dx            <= n_dx;
            r_dy            <= n_dy;
            r_comp          <= n_comp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire && w_result) begin
            r_out_acc  <= w_accept;
            r_out_comp <= w_accept ? n_comp : '0;
            r_out_dx   <= w_accept ? r_saved_x : '0;
            r_out_dy   <= w_accept ? r_saved_y : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_fire && r_in_last)) begin
            r_da_valid <= 1'b0;
            r_db_valid <= 1'b0;
            r_dc_valid <= 1'b0;
        end else begin
            r_da_valid <= w_fire && w_density_go;
            r_db_valid <= r_da_valid;
            r_dc_valid <= r_db_valid;
        end
        if (w_fire && w_density_go) begin
            r_da_units <= r_units;
            r_da_v[0]  <= r_dx;
            r_da_v[1]  <= n_dy;
        end
        r_db_units <= r_da_units;
        r_dc_units <= r_db_units;
        for (int i = 0; i < 2; i++) begin
            r_db_m[i]    <= ({13'b0, r_da_v[i]} * INCH_MUL) + 29'(INCH_ADD);
            r_db_h[i]    <= {7'b0, r_da_v[i]} * CM_MUL;
            r_dc_m[i]    <= r_db_m[i];
            r_dc_h[i]    <= r_db_h[i];
            r_dc_prod[i] <= {30'b0, r_db_m[i]} * INCH_RECIP;
        end
    end

    // The reciprocal product is exact or one short; a remainder check fixes it.
    always_comb begin
        t_dpm        q0;
        logic [29:0] rem;
        for (int i = 0; i < 2; i++) begin
            q0  = r_dc_prod[i][INCH_SHIFT +: 23];
            rem = {1'b0, r_dc_m[i]} - ({q0, 7'b0} - {7'b0, q0});
            if (rem >= 30'(INCH_DIV)) begin
                q0 = q0 + 23'd1;
            end
            if (r_dc_units == UNITS_INCH) begin
                w_dpm[i] = q0;
            end else if (r_dc_units == UNITS_CM) begin
                w_dpm[i] = r_dc_h[i];
            end else begin
                w_dpm[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_fire && r_in_last)) begin
            r_saved_x <= '0;
            r_saved_y <= '0;
        end else if (r_dc_valid) begin
            r_saved_x <= w_dpm[0];
            r_saved_y <= w_dpm[1];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_accepted         = r_out_acc;
    assign o_component_count  = r_out_comp;
    assign o_dots_per_meter_x = r_out_dx;
    assign o_dots_per_meter_y = r_out_dy;

    a_accept_components : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted)
        |-> (o_component_count == COMP_GREY || o_component_count == COMP_COLOUR))
        else $error("Accepted word carries an invalid component count.");

    a_reject_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_accepted)
        |-> (o_component_count == '0 && o_dots_per_meter_x == '0
             && o_dots_per_meter_y == '0))
        else $error("Reject word carries non-zero fields.");

    a_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_last) |=> (r_phase == PH_SOI0 && !r_verdict_given))
        else $error("Parser did not restart after the final byte.");

    a_density_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_da_valid, r_db_valid, r_dc_valid}))
        else $error("Two density conversions in flight at once.");

endmodule

>>> tb/sv/tb_jpeg_baseline_marker_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the JPEG baseline marker check
// Feeds whole files one byte per word: a short table of hand-built files,
// then random files that are mostly well formed, with corrupted, truncated
// and noise files among them. Each verdict word is compared field by field
// with a verdict set in the table or from the testbench's behavioural parser.
// ---------------------------------------------------------------------------
module tb_jpeg_baseline_marker_check;
    import jbmc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned TOTAL_BYTES  = 1100;
    localparam int unsigned MIN_FILES    = 24;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int          DIRECTED_ROWS = 26;
    localparam logic [39:0] JFIF_ID = 40'h4A46494600;

    typedef enum logic [1:0] {OUT_NONE, OUT_REJECT, OUT_ACCEPT} t_outcome;
    typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_VERDICT} t_row_kind;

    typedef struct packed {
        logic  acc;
        t_byte comps;
        t_dpm  dpm_x;
        t_dpm  dpm_y;
    } t_verdict;

    typedef struct packed {
        t_byte     b;
        logic      last;
        t_row_kind kind;
        t_verdict  v;
    } t_dir_row;

    localparam t_verdict ALL_ZERO       = '0;
    localparam t_verdict COLOUR_NO_JFIF = '{1'b1, COMP_COLOUR, 23'd0, 23'd0};

    // Hand-built files: a bad first byte, a bad second byte, a scan marker
    // followed by an ignored final byte, a short SOF0 whose component byte
    // lies beyond the segment, and a length below the minimum.
    t_dir_row directed_rows [DIRECTED_ROWS] = '{
        '{8'h00, 1'b1, ROW_VERDICT, ALL_ZERO},
        '{8'hFF, 1'b0, ROW_NONE,    ALL_ZERO},
        '{8'h00, 1'b1, ROW_VERDICT, ALL_ZERO},
        '{8'hFF, 1'b0, ROW_PREDICT, ALL_ZERO},
        '{8'hD8, 1'b0, ROW_PREDICT, ALL_ZERO},
        '{8'hFF, 1'b0, ROW_NONE,    ALL_ZERO},
        '{8'hDA, 1'b0, ROW_VERDICT, ALL_ZERO},
        '{8'h00, 1'b1, ROW_NONE,    ALL_ZERO},
        '{8'hFF, 1'b0, ROW_NONE,    ALL_ZERO},
        '{8'hD8, 1'b0, ROW_NONE,    ALL_ZERO},
        '{8'hFF, 1'b0, ROW_NONE,    ALL_ZERO},
        '{8'hC0, 1'b0, ROW_NONE,    ALL_ZERO},
        '{8'h00, 1'b0, ROW_PREDICT, ALL_ZERO},
        '{8'h02, 1'b0, ROW_PREDICT, ALL_ZERO},
        '{8'hFF, 1'b0, ROW_PREDICT, ALL_ZERO},
        '{8'h00, 1'b0, ROW_PREDICT, ALL_ZERO},
        '{8'h80, 1'b0, ROW_PREDICT, ALL_ZERO},
        '{8'h7F, 1'b0, ROW_PREDICT, ALL_ZERO},
        '{8'h01, 1'b0, ROW_PREDICT, ALL_ZERO},
        '{8'h03, 1'b1, ROW_VERDICT, COLOUR_NO_JFIF},
        '{8'hFF, 1'b0, ROW_NONE,    ALL_ZERO},
        '{8'hD8, 1'b0, ROW_NONE,    ALL_ZERO},
        '{8'hFF, 1'b0, ROW_NONE,    ALL_ZERO},
        '{8'hE1, 1'b0, ROW_NONE,    ALL_ZERO},
        '{8'h00, 1'b0, ROW_NONE,    ALL_ZERO},
        '{8'h01, 1'b1, ROW_VERDICT, ALL_ZERO}
    };

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    t_byte i_byte_value = '0;
    logic  i_last_byte = 1'b0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    logic  o_accepted;
    t_byte o_component_count;
    t_dpm  o_dots_per_meter_x;
    t_dpm  o_dots_per_meter_y;

    jpeg_baseline_marker_check uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_byte_value       (i_byte_value),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_accepted         (o_accepted),
        .o_component_count  (o_component_count),
        .o_dots_per_meter_x (o_dots_per_meter_x),
        .o_dots_per_meter_y (o_dots_per_meter_y)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_verdict    verdicts_due [$];
    t_byte       file_bytes [$];
    int unsigned fails = 0;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    bit          no_idle = 1'b0;

    // Parser state of the behavioural model.
    t_phase      ph;
    t_offset     seg_off;
    t_length     seg_len;
    t_byte       seg_marker;
    bit          jfif_sig_ok;
    t_byte       jfif_units;
    logic [15:0] jfif_x;
    logic [15:0] jfif_y;
    t_dpm        jfif_dpm_x;
    t_dpm        jfif_dpm_y;
    t_byte       sof_comps;
    bit          file_decided;

    function automatic void clear_parser();
        ph = PH_SOI0;
        seg_off = '0;
        seg_len = '0;
        seg_marker = '0;
        jfif_sig_ok = 1'b0;
        jfif_units = '0;
        jfif_x = '0;
        jfif_y = '0;
        jfif_dpm_x = '0;
        jfif_dpm_y = '0;
        sof_comps = '0;
        file_decided = 1'b0;
    endfunction

    function automatic t_dpm density_to_dpm(t_byte units, logic [15:0] v);
        int unsigned w;
        w = 0;
        if (units == UNITS_INCH) begin
            w = (32'(v) * 10000 + 127) / 254;
        end else if (units == UNITS_CM) begin
            w = 32'(v) * 100;
        end
        return t_dpm'(w);
    endfunction

    function automatic bit marker_is_sof();
        return seg_marker == MK_SOF0 || seg_marker == MK_SOF1;
    endfunction

    function automatic t_outcome segment_end();
        t_offset target;
        target = t_offset'(seg_len) + 17'd1;
        if (marker_is_sof() && target < OFF_COMP) begin
            target = OFF_COMP;
        end
        if (seg_off >= target) begin
            if (marker_is_sof()) begin
                return OUT_ACCEPT;
            end
            ph = PH_PREFIX;
        end else begin
            ph = PH_BODY;
        end
        return OUT_NONE;
    endfunction

    function automatic t_outcome body_byte(t_byte b);
        bit ok;
        if (seg_marker == MK_APP0 && seg_len >= LEN_JFIF_MIN) begin
            if (seg_off >= OFF_SIG_FIRST && seg_off <= OFF_SIG_LAST) begin
                ok = (b == JFIF_ID[8 * (OFF_SIG_LAST - seg_off) +: 8]);
                jfif_sig_ok = (seg_off == OFF_SIG_FIRST) ? ok : (jfif_sig_ok & ok);
            end else if (seg_off == OFF_UNITS) begin
                jfif_units = b;
            end else if (seg_off == OFF_XHI) begin
                jfif_x = {b, 8'h00};
            end else if (seg_off == OFF_XLO) begin
                jfif_x[7:0] = b;
            end else if (seg_off == OFF_YHI) begin
                jfif_y = {b, 8'h00};
            end else if (seg_off == OFF_YLO) begin
                jfif_y[7:0] = b;
                if (jfif_sig_ok) begin
                    jfif_dpm_x = density_to_dpm(jfif_units, jfif_x);
                    jfif_dpm_y = density_to_dpm(jfif_units, jfif_y);
                end
            end
        end
        if (marker_is_sof() && seg_off == OFF_COMP) begin
            sof_comps = b;
            if (b != COMP_GREY && b != COMP_COLOUR) begin
                return OUT_REJECT;
            end
        end
        return OUT_NONE;
    endfunction

    task automatic parse_byte(input t_byte b, input logic last, output bit emitted,
                              output t_verdict v);
        t_outcome res;
        res = OUT_NONE;
        emitted = 1'b0;
        v = ALL_ZERO;
        if (!file_decided) begin
            case (ph)
                PH_SOI0: begin
                    if (b != MK_PREFIX) res = OUT_REJECT;
                    else ph = PH_SOI1;
                end
                PH_SOI1: begin
                    if (b != MK_SOI) res = OUT_REJECT;
                    else ph = PH_PREFIX;
                end
                PH_PREFIX: begin
                    if (b != MK_PREFIX) res = OUT_REJECT;
                    else ph = PH_MARKER;
                end
                PH_MARKER: begin
                    if (b == MK_SOI || b == MK_TEM || (b >= MK_RST_LO && b <= MK_RST_HI)) begin
                        ph = PH_PREFIX;
                    end else if ((b >= MK_SOF_LO && b <= MK_SOF_HI && b != MK_DHT
                                  && b != MK_JPG && b != MK_DAC) || b == MK_SOS) begin
                        res = OUT_REJECT;
                    end else begin
                        seg_marker = b;
                        ph = PH_LENHI;
                    end
                end
                PH_LENHI: begin
                    seg_len = {b, 8'h00};
                    ph = PH_LENLO;
                end
                PH_LENLO: begin
                    seg_len[7:0] = b;
                    if (seg_len < LEN_MIN) begin
                        res = OUT_REJECT;
                    end else begin
                        seg_off = OFF_LEN_DONE;
                        jfif_sig_ok = 1'b0;
                        res = segment_end();
                    end
                end
                PH_BODY: begin
                    seg_off = seg_off + 17'd1;
                    res = body_byte(b);
                    if (res == OUT_NONE) res = segment_end();
                end
                default: res = OUT_REJECT;
            endcase
        end
        if (res != OUT_NONE || (last && !file_decided)) begin
            emitted = 1'b1;
            if (res == OUT_ACCEPT) begin
                v = '{1'b1, sof_comps, jfif_dpm_x, jfif_dpm_y};
            end
            file_decided = 1'b1;
        end
        if (last) clear_parser();
    endtask

    task automatic push_byte(input t_byte b, input logic last, input t_row_kind kind,
                             input t_verdict typed_v);
        bit       emitted;
        t_verdict v;
        while (!no_idle && $urandom_range(99) < 11) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_value <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
        parse_byte(b, last, emitted, v);
        if (kind == ROW_VERDICT) verdicts_due.push_back(typed_v);
        else if (kind == ROW_PREDICT && emitted) verdicts_due.push_back(v);
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic void add_segment_head(t_byte mk, int unsigned len);
        file_bytes.push_back(MK_PREFIX);
        file_bytes.push_back(mk);
        file_bytes.push_back(t_byte'(len >> 8));
        file_bytes.push_back(t_byte'(len));
    endfunction

    function automatic logic [15:0] pick_density();
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void add_jfif();
        int unsigned len;
        int unsigned spoil_at;
        t_byte       units;
        logic [15:0] x;
        logic [15:0] y;
        t_byte       b;
        len = ($urandom_range(7) == 0) ? $urandom_range(2, 15) : $urandom_range(16, 19);
        spoil_at = ($urandom_range(6) == 0) ? $urandom_range(4, 8) : 0;
        units = ($urandom_range(3) == 0) ? t_byte'($urandom) : t_byte'($urandom_range(0, 2));
        x = pick_density();
        y = pick_density();
        add_segment_head(MK_APP0, len);
        for (int unsigned off = 4; off <= len + 1; off++) begin
            case (off)
                4, 5, 6, 7, 8: begin
                    b = JFIF_ID[8 * (8 - off) +: 8];
                    if (off == spoil_at) b = b ^ t_byte'($urandom_range(1, 255));
                end
                11: b = units;
                12: b = x[15:8];
                13: b = x[7:0];
                14: b = y[15:8];
                15: b = y[7:0];
                default: b = t_byte'($urandom);
            endcase
            file_bytes.push_back(b);
        end
    endfunction

    function automatic void add_sof();
        t_byte       mk;
        t_byte       comp;
        int unsigned len;
        int unsigned last_off;
        mk = $urandom_range(1) ? MK_SOF0 : MK_SOF1;
        if ($urandom_range(6) == 0) comp = t_byte'($urandom);
        else comp = $urandom_range(1) ? COMP_GREY : COMP_COLOUR;
        if ($urandom_range(7) == 0) len = $urandom_range(2, 10);
        else len = 8 + 3 * ((comp == COMP_GREY) ? 1 : 3);
        last_off = (len + 1 > 9) ? len + 1 : 9;
        if (comp != COMP_GREY && comp != COMP_COLOUR) last_off = 9;
        add_segment_head(mk, len);
        for (int unsigned off = 4; off <= last_off; off++) begin
            file_bytes.push_back((off == 9) ? comp : t_byte'($urandom));
        end
    endfunction

    function automatic void add_other_segment();
        t_byte       mk;
        int unsigned len;
        case ($urandom_range(4))
            0: begin
                file_bytes.push_back(MK_PREFIX);
                case ($urandom_range(2))
                    0: file_bytes.push_back(MK_SOI);
                    1: file_bytes.push_back(MK_TEM);
                    default: file_bytes.push_back(t_byte'($urandom_range(MK_RST_LO, MK_RST_HI)));
                endcase
            end
            1, 2: add_jfif();
            default: begin
                if ($urandom_range(3) == 0) begin
                    case ($urandom_range(2))
                        0: mk = MK_DHT;
                        1: mk = MK_JPG;
                        default: mk = MK_DAC;
                    endcase
                end else begin
                    do mk = t_byte'($urandom);
                    while (mk == MK_SOI || mk == MK_TEM || (mk >= MK_RST_LO && mk <= MK_RST_HI)
                           || mk == MK_SOS || (mk >= MK_SOF_LO && mk <= MK_SOF_HI)
                           || mk == MK_SOF0 || mk == MK_SOF1 || mk == MK_APP0);
                end
                len = $urandom_range(2, 12);
                add_segment_head(mk, len);
                repeat (len - 2) file_bytes.push_back(t_byte'($urandom));
            end
        endcase
    endfunction

    task automatic build_file();
        int unsigned kind;
        int unsigned cut;
        t_byte       mk;
        file_bytes = {};
        kind = $urandom_range(99);
        if (kind >= 90) begin
            if ($urandom_range(1)) begin
                file_bytes.push_back(MK_PREFIX);
                file_bytes.push_back(MK_SOI);
            end
            repeat ($urandom_range(1, 12)) file_bytes.push_back(t_byte'($urandom));
            return;
        end
        file_bytes.push_back(MK_PREFIX);
        file_bytes.push_back(MK_SOI);
        repeat ($urandom_range(0, 4)) add_other_segment();
        case ($urandom_range(11))
            0: begin
                file_bytes.push_back(MK_PREFIX);
                file_bytes.push_back(MK_SOS);
            end
            1: begin
                do mk = t_byte'($urandom_range(MK_SOF_LO, MK_SOF_HI));
                while (mk == MK_DHT || mk == MK_JPG || mk == MK_DAC);
                file_bytes.push_back(MK_PREFIX);
                file_bytes.push_back(mk);
            end
            2: file_bytes.push_back(t_byte'($urandom_range(0, 8'hFE)));
            3: begin
                // A long segment that the end of the file cuts off.
                add_segment_head(t_byte'($urandom_range(8'hE1, 8'hEF)), $urandom_range(256, 65535));
                repeat ($urandom_range(0, 6)) file_bytes.push_back(t_byte'($urandom));
            end
            4: ;
            default: add_sof();
        endcase
        repeat ($urandom_range(0, 5)) file_bytes.push_back(t_byte'($urandom));
        if (kind >= 75) begin
            file_bytes[$urandom_range(0, file_bytes.size() - 1)] = t_byte'($urandom);
        end
        if ($urandom_range(9) == 0) begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
    endtask

    t_verdict due_v;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdicts_due.size() == 0) begin
                $error("verdict word with no verdict expected");
                fails++;
            end else begin
                due_v = verdicts_due.pop_front();
                if (o_accepted !== due_v.acc) begin
                    $error("accepted: expected %0d, got %0d", due_v.acc, o_accepted);
                    fails++;
                end
                if (o_component_count !== due_v.comps) begin
                    $error("component_count: expected %0d, got %0d", due_v.comps,
                           o_component_count);
                    fails++;
                end
                if (o_dots_per_meter_x !== due_v.dpm_x) begin
                    $error("dots_per_meter_x: expected %0d, got %0d", due_v.dpm_x,
                           o_dots_per_meter_x);
                    fails++;
                end
                if (o_dots_per_meter_y !== due_v.dpm_y) begin
                    $error("dots_per_meter_y: expected %0d, got %0d", due_v.dpm_y,
                           o_dots_per_meter_y);
                    fails++;
                end
            end
        end
        i_out_ready <= no_idle || ($urandom_range(99) >= 11);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int unsigned files_done;
        files_done = 0;
        clear_parser();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            push_byte(directed_rows[r].b, directed_rows[r].last, directed_rows[r].kind,
                      directed_rows[r].v);
        end
        hold_until_drained();

        while (bytes_sent < TOTAL_BYTES || files_done < MIN_FILES) begin
            if (files_done == 10) hold_until_drained();
            no_idle <= (files_done >= 14 && files_done < 24);
            build_file();
            foreach (file_bytes[k]) begin
                push_byte(file_bytes[k], k == file_bytes.size() - 1, ROW_PREDICT, ALL_ZERO);
            end
            files_done++;
        end

        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
